### hdl/assert_macros.svh
// assertion helpers used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define PBFS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// trigger in one cycle implies the consequent in the next cycle
`define PBFS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

// trigger implies the consequent in the same cycle
`define PBFS_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

### hdl/pbfs_pkg.sv
// ----------------------------------------------------------------------------
// pbfs_pkg
// shared types and constants of the paged best-fit suballocator
// ----------------------------------------------------------------------------
`default_nettype none

package pbfs_pkg;

    localparam int unsigned MAX_PAGES_DEF  = 16;
    localparam int unsigned FREE_SLOTS_DEF = 16;

    localparam logic [31:0] DPS_RESET   = 32'd8388608;
    localparam logic [16:0] ALIGN_RESET = 17'd256;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SLOT   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_LIST_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic REG_DPS   = 1'b0;
    localparam logic REG_ALIGN = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [3:0]  release_slot;
        logic [31:0] release_offset;
        logic [31:0] release_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  page_slot;
        logic [31:0] section_offset;
        logic [31:0] granted_bytes;
        logic [31:0] created_page_bytes;
        logic        page_dropped;
        logic [36:0] total_bytes;
    } res_t;

endpackage

`default_nettype wire

### hdl/pbfs_align.sv
// ----------------------------------------------------------------------------
// pbfs_align
// rounds a size up to a multiple of the alignment, one remainder bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pbfs_align (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] req_bytes,
    input  logic [16:0] align,
    output logic        done,
    output logic [32:0] aligned
);

    logic [32:0] xo_reg;
    logic [32:0] sh_reg;
    logic [16:0] div_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] div_w;
    logic [32:0] x_w;
    logic [17:0] trial;

    assign div_w = (align == 17'd0) ? 17'd1 : align;
    assign x_w   = {1'b0, req_bytes} + {16'b0, div_w} - 33'd1;
    assign trial = {rem_reg, sh_reg[32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            xo_reg   <= 33'd0;
            sh_reg   <= 33'd0;
            div_reg  <= 17'd1;
            rem_reg  <= 17'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
                xo_reg   <= x_w;
                sh_reg   <= x_w;
                div_reg  <= div_w;
                rem_reg  <= 17'd0;
            end
            else if (busy_reg)
            begin
                sh_reg <= {sh_reg[31:0], 1'b0};
                if (trial >= {1'b0, div_reg})
                    rem_reg <= 17'(trial - {1'b0, div_reg});
                else
                    rem_reg <= trial[16:0];
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign aligned = xo_reg - {16'b0, rem_reg};

endmodule

`default_nettype wire

### hdl/pbfs_engine.sv
// ----------------------------------------------------------------------------
// pbfs_engine
// page table, free-list memory and the allocate / release sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module pbfs_engine #(
    parameter int unsigned MAX_PAGES  = 16,
    parameter int unsigned FREE_SLOTS = 16,
    localparam int unsigned LW = $clog2(MAX_PAGES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pbfs_pkg::req_t req,
    input  logic [31:0]   dps,
    input  logic [16:0]   align,
    output logic          ready,
    output logic          res_valid,
    input  logic          res_ready,
    output pbfs_pkg::res_t res,
    output logic [LW-1:0] live_count
);

    import pbfs_pkg::*;

    localparam int unsigned SW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned CW    = $clog2(FREE_SLOTS + 1);
    localparam int unsigned DEPTH = MAX_PAGES * FREE_SLOTS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] FS_W  = (AW + 1)'(FREE_SLOTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ALIGN = 4'd1;
    localparam logic [3:0] S_PAGE  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_TAKE  = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_BUMP  = 4'd7;
    localparam logic [3:0] S_REL   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // page table
    logic [MAX_PAGES-1:0] live_reg;
    logic [31:0]   bytes_reg [MAX_PAGES];
    logic [31:0]   fill_reg  [MAX_PAGES];
    logic [31:0]   users_reg [MAX_PAGES];
    logic [SW-1:0] rank_reg  [MAX_PAGES];
    logic [CW-1:0] fcnt_reg  [MAX_PAGES];
    logic [LW-1:0] livecnt_reg;
    logic [36:0]   pool_reg;

    // free-list memory, {bytes, offset}
    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    logic [3:0]    state_reg;
    req_t          req_reg;
    logic          bad_slot_reg;
    logic [31:0]   need_reg;
    logic [SW-1:0] cur_slot_reg;
    logic [LW-1:0] r_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] pick_reg;
    logic [31:0]   pick_off_reg;
    logic [31:0]   pick_bytes_reg;
    logic [31:0]   best_reg;
    logic          have_reg;
    res_t          out_reg;

    logic          al_done;
    logic [32:0]   al_aligned;

    logic [SW-1:0] found_slot;
    logic [SW-1:0] free_slot;
    logic          have_free;
    logic [SW-1:0] base_slot;
    logic [AW:0]   base_w;
    logic [CW:0]   rd_off;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [31:0]   cur_bytes;
    logic [31:0]   cur_fill;
    logic [31:0]   cur_users;
    logic [CW-1:0] cur_fcnt;
    logic [31:0]   users_dec;
    logic          fits;
    logic [31:0]   ent_bytes;
    logic [31:0]   ent_off;
    logic          mk_en;
    logic [31:0]   mk_bytes;
    logic [31:0]   mk_fill;
    logic [31:0]   mk_users;
    logic          drop_en;
    logic          append_en;

    pbfs_align u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && req.opcode == OP_ALLOC),
        .req_bytes (req.request_bytes),
        .align     (align),
        .done      (al_done),
        .aligned   (al_aligned)
    );

    // page of a given rank and first empty slot
    always_comb
    begin
        found_slot = '0;
        free_slot  = '0;
        have_free  = 1'b0;
        for (int t = MAX_PAGES - 1; t >= 0; t--)
        begin
            if (live_reg[t] && rank_reg[t] == SW'(r_reg))
                found_slot = SW'(t);
            if (!live_reg[t])
            begin
                free_slot = SW'(t);
                have_free = 1'b1;
            end
        end
    end

    assign cur_bytes = bytes_reg[cur_slot_reg];
    assign cur_fill  = fill_reg[cur_slot_reg];
    assign cur_users = users_reg[cur_slot_reg];
    assign cur_fcnt  = fcnt_reg[cur_slot_reg];
    assign users_dec = (cur_users == 32'd0) ? 32'd0 : cur_users - 32'd1;
    assign fits      = ({1'b0, cur_fill} + {1'b0, need_reg}) <= {1'b0, cur_bytes};
    assign ent_bytes = rd_data_reg[63:32];
    assign ent_off   = rd_data_reg[31:0];

    assign base_slot = (state_reg == S_PAGE) ? found_slot : cur_slot_reg;
    assign base_w    = (AW + 1)'(base_slot) * FS_W;

    always_comb
    begin
        case (state_reg)
            S_SCAN:  rd_off = {1'b0, k_reg} + (CW + 1)'(1);
            S_TAKE:  rd_off = {1'b0, pick_reg} + (CW + 1)'(1);
            S_SHIFT: rd_off = {1'b0, k_reg} + (CW + 1)'(2);
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = AW'(base_w + (AW + 1)'(rd_off));

    // release decision
    assign drop_en = (state_reg == S_REL) && !bad_slot_reg && live_reg[cur_slot_reg]
                     && (req_reg.release_bytes == cur_bytes
                         || (cur_fcnt < CW'(FREE_SLOTS) && users_dec == 32'd0
                             && livecnt_reg > LW'(1)));
    assign append_en = (state_reg == S_REL) && !bad_slot_reg && live_reg[cur_slot_reg]
                       && req_reg.release_bytes != cur_bytes
                       && cur_fcnt < CW'(FREE_SLOTS);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(base_w + (AW + 1)'(k_reg));
        wr_data = rd_data_reg;
        if (state_reg == S_SHIFT)
            wr_en = 1'b1;
        else if (append_en)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(base_w + (AW + 1)'(cur_fcnt));
            wr_data = {req_reg.release_bytes, req_reg.release_offset};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // page creation requests
    always_comb
    begin
        mk_en    = 1'b0;
        mk_bytes = dps;
        mk_fill  = 32'd0;
        mk_users = 32'd0;
        if (state_reg == S_ALIGN && al_done && !al_aligned[32])
        begin
            if (al_aligned[31:0] > dps)
            begin
                mk_en    = have_free;
                mk_bytes = al_aligned[31:0];
                mk_fill  = al_aligned[31:0];
                mk_users = 32'd1;
            end
            else if (livecnt_reg == '0)
                mk_en = have_free;
        end
        else if (state_reg == S_BUMP && !fits && r_reg + LW'(1) == livecnt_reg)
            mk_en = have_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            livecnt_reg    <= '0;
            pool_reg       <= '0;
            req_reg        <= '0;
            bad_slot_reg   <= 1'b0;
            need_reg       <= '0;
            cur_slot_reg   <= '0;
            r_reg          <= '0;
            k_reg          <= '0;
            pick_reg       <= '0;
            pick_off_reg   <= '0;
            pick_bytes_reg <= '0;
            best_reg       <= '0;
            have_reg       <= 1'b0;
            out_reg        <= '0;
            for (int t = 0; t < MAX_PAGES; t++)
            begin
                bytes_reg[t] <= '0;
                fill_reg[t]  <= '0;
                users_reg[t] <= '0;
                rank_reg[t]  <= '0;
                fcnt_reg[t]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg      <= req;
                        out_reg      <= '0;
                        cur_slot_reg <= SW'(req.release_slot);
                        bad_slot_reg <= 32'(req.release_slot) >= 32'(MAX_PAGES);
                        state_reg    <= (req.opcode == OP_RELEASE) ? S_REL : S_ALIGN;
                    end
                end
                S_ALIGN:
                begin
                    if (al_done)
                    begin
                        need_reg <= al_aligned[31:0];
                        r_reg    <= '0;
                        if (al_aligned[32])
                        begin
                            out_reg.status <= ST_OVERFLOW;
                            state_reg      <= S_DONE;
                        end
                        else if (al_aligned[31:0] > dps)
                        begin
                            state_reg <= S_DONE;
                            if (!have_free)
                                out_reg.status <= ST_NO_SLOT;
                            else
                            begin
                                out_reg.page_slot          <= 4'(free_slot);
                                out_reg.granted_bytes      <= al_aligned[31:0];
                                out_reg.created_page_bytes <= al_aligned[31:0];
                            end
                        end
                        else
                        begin
                            if (livecnt_reg == '0)
                                out_reg.created_page_bytes <= dps;
                            state_reg <= S_PAGE;
                        end
                    end
                end
                S_PAGE:
                begin
                    cur_slot_reg <= found_slot;
                    k_reg        <= '0;
                    have_reg     <= 1'b0;
                    state_reg    <= (fcnt_reg[found_slot] == '0) ? S_BUMP : S_SCAN;
                end
                S_SCAN:
                begin
                    if (ent_bytes == need_reg)
                    begin
                        pick_reg       <= k_reg;
                        pick_off_reg   <= ent_off;
                        pick_bytes_reg <= ent_bytes;
                        state_reg      <= S_TAKE;
                    end
                    else
                    begin
                        if (ent_bytes > need_reg
                            && (!have_reg || ent_bytes - need_reg < best_reg))
                        begin
                            have_reg       <= 1'b1;
                            best_reg       <= ent_bytes - need_reg;
                            pick_reg       <= k_reg;
                            pick_off_reg   <= ent_off;
                            pick_bytes_reg <= ent_bytes;
                        end
                        if (k_reg + CW'(1) == cur_fcnt)
                            state_reg <= S_EVAL;
                        else
                            k_reg <= k_reg + CW'(1);
                    end
                end
                S_EVAL:
                begin
                    // least-waste entry only while waste stays under twice the size
                    if (have_reg && {1'b0, best_reg} < {need_reg, 1'b0})
                        state_reg <= S_TAKE;
                    else
                        state_reg <= S_BUMP;
                end
                S_TAKE:
                begin
                    if ({1'b0, pick_reg} + (CW + 1)'(1) >= {1'b0, cur_fcnt})
                    begin
                        fcnt_reg[cur_slot_reg]  <= cur_fcnt - CW'(1);
                        users_reg[cur_slot_reg] <= cur_users + 32'd1;
                        out_reg.page_slot       <= 4'(cur_slot_reg);
                        out_reg.section_offset  <= pick_off_reg;
                        out_reg.granted_bytes   <= pick_bytes_reg;
                        state_reg               <= S_DONE;
                    end
                    else
                    begin
                        k_reg     <= pick_reg;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if ({1'b0, k_reg} + (CW + 1)'(2) < {1'b0, cur_fcnt})
                        k_reg <= k_reg + CW'(1);
                    else
                    begin
                        fcnt_reg[cur_slot_reg]  <= cur_fcnt - CW'(1);
                        users_reg[cur_slot_reg] <= cur_users + 32'd1;
                        out_reg.page_slot       <= 4'(cur_slot_reg);
                        out_reg.section_offset  <= pick_off_reg;
                        out_reg.granted_bytes   <= pick_bytes_reg;
                        state_reg               <= S_DONE;
                    end
                end
                S_BUMP:
                begin
                    if (fits)
                    begin
                        fill_reg[cur_slot_reg]  <= cur_fill + need_reg;
                        users_reg[cur_slot_reg] <= cur_users + 32'd1;
                        out_reg.page_slot       <= 4'(cur_slot_reg);
                        out_reg.section_offset  <= cur_fill;
                        out_reg.granted_bytes   <= need_reg;
                        state_reg               <= S_DONE;
                    end
                    else if (r_reg + LW'(1) == livecnt_reg)
                    begin
                        if (!have_free)
                        begin
                            out_reg.status <= ST_NO_SLOT;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            out_reg.created_page_bytes <= dps;
                            r_reg     <= r_reg + LW'(1);
                            state_reg <= S_PAGE;
                        end
                    end
                    else
                    begin
                        r_reg     <= r_reg + LW'(1);
                        state_reg <= S_PAGE;
                    end
                end
                S_REL:
                begin
                    out_reg.page_slot <= req_reg.release_slot;
                    state_reg         <= S_DONE;
                    if (bad_slot_reg || !live_reg[cur_slot_reg])
                        out_reg.status <= ST_NOT_FOUND;
                    else if (req_reg.release_bytes != cur_bytes)
                    begin
                        if (cur_fcnt >= CW'(FREE_SLOTS))
                            out_reg.status <= ST_LIST_FULL;
                        else
                        begin
                            // a dropped page clears its count below
                            if (!drop_en)
                                fcnt_reg[cur_slot_reg] <= cur_fcnt + CW'(1);
                            users_reg[cur_slot_reg] <= users_dec;
                        end
                    end
                    if (drop_en)
                        out_reg.page_dropped <= 1'b1;
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (mk_en)
            begin
                live_reg[free_slot]  <= 1'b1;
                bytes_reg[free_slot] <= mk_bytes;
                fill_reg[free_slot]  <= mk_fill;
                users_reg[free_slot] <= mk_users;
                rank_reg[free_slot]  <= SW'(livecnt_reg);
                fcnt_reg[free_slot]  <= '0;
                livecnt_reg          <= livecnt_reg + LW'(1);
                pool_reg             <= pool_reg + {5'b0, mk_bytes};
            end

            if (drop_en)
            begin
                // keep creation ranks contiguous
                for (int t = 0; t < MAX_PAGES; t++)
                    if (live_reg[t] && SW'(t) != cur_slot_reg
                        && rank_reg[t] > rank_reg[cur_slot_reg])
                        rank_reg[t] <= rank_reg[t] - SW'(1);
                live_reg[cur_slot_reg] <= 1'b0;
                fcnt_reg[cur_slot_reg] <= '0;
                livecnt_reg            <= livecnt_reg - LW'(1);
                pool_reg               <= pool_reg - {5'b0, cur_bytes};
            end
        end
    end

    assign ready      = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign live_count = livecnt_reg;

    always_comb
    begin
        res             = out_reg;
        res.total_bytes = pool_reg;
    end

endmodule

`default_nettype wire

### hdl/paged_best_fit_suballocator_core.sv
// ----------------------------------------------------------------------------
// paged_best_fit_suballocator_core
// paged suballocator with per-page best-fit free lists and bump allocation
// ----------------------------------------------------------------------------
// a release goes from accept through the release check to its result; an allocate runs
//   the 33-step alignment divider and the size decision, then per page a lookup, a scan
//   of its free entries, a fit check after a scan and a shift of the entries behind a pick
// one request at a time; the next is accepted once the engine has passed on its result
// reset: asynchronous active low, clears page table and counters at once,
//   the free-list memory needs no clearing pass (read only after written)
`default_nettype none

`include "assert_macros.svh"

module paged_best_fit_suballocator_core #(
    parameter int unsigned MAX_PAGES  = pbfs_pkg::MAX_PAGES_DEF,
    parameter int unsigned FREE_SLOTS = pbfs_pkg::FREE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // request_bytes, release_slot, release_offset, release_bytes, zero pad
    input  logic [103:0] s_tdata,
    // opcode
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, page_slot, section_offset, granted_bytes, created_page_bytes,
    // page_dropped, total_bytes, zero pad
    output logic [143:0] m_tdata
);

    import pbfs_pkg::*;

    localparam int unsigned LW = $clog2(MAX_PAGES + 1);

    logic [31:0]   dps_reg;
    logic [16:0]   align_reg;
    logic          cfg_wr;

    req_t          req_w;
    res_t          eng_res;
    logic          eng_ready;
    logic          eng_valid;
    logic          eng_take;
    logic [LW-1:0] live_count;

    logic          m_tvalid_reg;
    res_t          m_res_reg;

    // register file, written on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dps_reg   <= DPS_RESET;
            align_reg <= ALIGN_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DPS)
                dps_reg <= pwdata;
            else
                align_reg <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == REG_ALIGN) ? {15'b0, align_reg} : dps_reg;

    // unpack the request
    assign req_w.opcode         = s_tuser[0];
    assign req_w.request_bytes  = s_tdata[31:0];
    assign req_w.release_slot   = s_tdata[35:32];
    assign req_w.release_offset = s_tdata[67:36];
    assign req_w.release_bytes  = s_tdata[99:68];

    // engine takes a new request whenever it is idle, even while a result waits
    assign s_tready = eng_ready;

    pbfs_engine #(
        .MAX_PAGES  (MAX_PAGES),
        .FREE_SLOTS (FREE_SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_tvalid && s_tready),
        .req        (req_w),
        .dps        (dps_reg),
        .align      (align_reg),
        .ready      (eng_ready),
        .res_valid  (eng_valid),
        .res_ready  (eng_take),
        .res        (eng_res),
        .live_count (live_count)
    );

    // output register parts the engine from the result stream
    assign eng_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_res_reg    <= '0;
        end
        else if (eng_take)
        begin
            m_tvalid_reg <= eng_valid;
            if (eng_valid)
                m_res_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b0,
                       m_res_reg.total_bytes,
                       m_res_reg.page_dropped,
                       m_res_reg.created_page_bytes,
                       m_res_reg.granted_bytes,
                       m_res_reg.section_offset,
                       m_res_reg.page_slot,
                       m_res_reg.status};

    // checks
    `PBFS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request overlap")
    `PBFS_ASSERT(a_live_bound, 32'(live_count) <= 32'(MAX_PAGES), "live page count overflow")
    `PBFS_ASSERT_SAME(a_drop_ok, m_tvalid && m_res_reg.page_dropped,
        m_res_reg.status == ST_OK && m_res_reg.granted_bytes == 32'd0, "drop with bad result")

endmodule

`default_nettype wire
